// ===== hdl/sled_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg: shared types, constants and a function of the escape decoder
// Holds the byte class record passed from front to back, the result record,
// the result kind codes and the queue sizing.
// ----------------------------------------------------------------------------
package sled_pkg;

  // Character codes the decoder looks at.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ESC    = 8'h1B;

  // Saturation limit of both counters.
  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Depth of the queues between front and back and at the output.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_UNTERM = 2'd2,
    KIND_BADESC = 2'd3
  } kind_t;

  // Classification of one source byte, computed by the front.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_zero;
    logic       is_nl;
    logic       is_quote;
    logic       is_bslash;
    logic       is_space;
    logic       is_x;
    logic       esc_ok;
    logic [7:0] esc_val;
    logic       hex_ok;
    logic [3:0] hex_val;
  } cls_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] length;
    logic        empty_res;
    logic [15:0] newline_count;
  } res_t;

  // Sort one source byte into the classes the decoder state machine needs.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.ch        = c;
    r.is_zero   = (c == CH_NUL);
    r.is_nl     = (c == CH_NL);
    r.is_quote  = (c == CH_QUOTE);
    r.is_bslash = (c == CH_BSLASH);
    r.is_space  = (c != CH_NUL) && (c <= CH_SPACE);
    r.is_x      = (c == CH_X);
    // Single-character escapes.
    r.esc_ok  = 1'b1;
    r.esc_val = c;
    case (c)
      8'h6E:    r.esc_val = 8'h0A; // n
      8'h74:    r.esc_val = 8'h09; // t
      8'h72:    r.esc_val = 8'h0D; // r
      8'h62:    r.esc_val = 8'h08; // b
      8'h76:    r.esc_val = 8'h0B; // v
      8'h66:    r.esc_val = 8'h0C; // f
      8'h65:    r.esc_val = CH_ESC; // e
      8'h30:    r.esc_val = 8'h00; // digit zero
      CH_QUOTE, CH_APOS, CH_BSLASH: r.esc_val = c;
      default: begin
        r.esc_ok  = 1'b0;
        r.esc_val = 8'h00;
      end
    endcase
    // Hex digit value, either case.
    r.hex_ok  = 1'b1;
    r.hex_val = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      r.hex_val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r.hex_val = c[3:0] + 4'd9;
    end else begin
      r.hex_ok = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sled_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_front: input side of the escape decoder
// Accepts source bytes through the push/full handshake and classifies each
// one before it enters the class queue.
// ----------------------------------------------------------------------------
module sled_front
  import sled_pkg::*;
(
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  output logic            q_wr,
  output cls_t            q_data,
  input  wire logic       q_full
);

  // An item is taken whenever the class queue has room.
  assign full   = q_full;
  assign q_wr   = push && !q_full;
  assign q_data = classify(in_byte);

endmodule
`default_nettype wire

// ===== hdl/sled_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_queue: short queue of classified bytes
// Decouples the front from the back so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sled_queue
  import sled_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cls_t wr_data,
  output logic      full,
  input  wire logic rd,
  output cls_t      rd_data,
  output logic      valid
);

  cls_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rptr];

  // Storage is written at the tail; no reset needed.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sled_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_back: literal state machine and result queue
// Walks the classified bytes through the literal, escape, hex and gap modes,
// keeps the length and newline counts, and queues the result items.
// ----------------------------------------------------------------------------
module sled_back
  import sled_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cls_t q_data,
  output logic      q_rd,
  output logic      empty,
  input  wire logic pop,
  output res_t      res
);

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_TEXT = 3'd1,
    M_ESC  = 3'd2,
    M_HEX1 = 3'd3,
    M_HEX2 = 3'd4,
    M_GAP  = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [3:0]  hex_high, hex_high_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] gap_newlines, gap_newlines_next;
  logic        out_wr;
  res_t        out_data;

  // Result queue storage.
  res_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              out_full;
  logic              out_rd;

  assign out_full = (count == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign out_rd   = pop && !empty;
  assign res      = slots[rptr];

  // A byte is consumed when one is waiting and a result has room.
  assign q_rd = q_valid && !out_full;

  // Next state and result for the byte at the head of the class queue.
  always_comb begin
    mode_next         = mode;
    hex_high_next     = hex_high;
    byte_count_next   = byte_count;
    gap_newlines_next = gap_newlines;
    out_wr            = 1'b0;
    out_data          = '{kind: KIND_BYTE, data_byte: 8'h00, length: 16'h0000,
                          empty_res: 1'b0, newline_count: 16'h0000};
    case (mode)
      M_TEXT: begin
        if (q_data.is_zero || q_data.is_nl) begin
          mode_next     = M_IDLE;
          out_wr        = 1'b1;
          out_data.kind = KIND_UNTERM;
        end else if (q_data.is_bslash) begin
          mode_next = M_ESC;
        end else if (q_data.is_quote) begin
          mode_next = M_GAP;
        end else begin
          out_wr             = 1'b1;
          out_data.data_byte = q_data.ch;
        end
      end
      M_ESC: begin
        if (q_data.esc_ok) begin
          mode_next          = M_TEXT;
          out_wr             = 1'b1;
          out_data.data_byte = q_data.esc_val;
        end else if (q_data.is_x) begin
          mode_next = M_HEX1;
        end else begin
          mode_next     = M_IDLE;
          out_wr        = 1'b1;
          out_data.kind = KIND_BADESC;
        end
      end
      M_HEX1: begin
        out_wr = !q_data.hex_ok;
        if (q_data.hex_ok) begin
          hex_high_next = q_data.hex_val;
          mode_next     = M_HEX2;
        end else begin
          mode_next     = M_IDLE;
          out_data.kind = KIND_BADESC;
        end
      end
      M_HEX2: begin
        out_wr = 1'b1;
        if (q_data.hex_ok) begin
          mode_next          = M_TEXT;
          out_data.data_byte = {hex_high, q_data.hex_val};
        end else begin
          mode_next     = M_IDLE;
          out_data.kind = KIND_BADESC;
        end
      end
      M_GAP: begin
        if (q_data.is_nl) begin
          if (gap_newlines != SAT16) begin
            gap_newlines_next = gap_newlines + 16'd1;
          end
        end else if (q_data.is_quote) begin
          mode_next = M_TEXT;
        end else if (!q_data.is_space) begin
          mode_next              = M_IDLE;
          out_wr                 = 1'b1;
          out_data.kind          = KIND_DONE;
          out_data.length        = byte_count;
          out_data.empty_res     = (byte_count == 16'h0000);
          out_data.newline_count = gap_newlines;
        end
      end
      default: begin
        // Idle: only an opening quote matters.
        if (q_data.is_quote) begin
          mode_next         = M_TEXT;
          byte_count_next   = 16'h0000;
          gap_newlines_next = 16'h0000;
        end else begin
          mode_next = M_IDLE;
        end
      end
    endcase
    // Every decoded byte bumps the saturating length.
    if (out_wr && out_data.kind == KIND_BYTE && byte_count != SAT16) begin
      byte_count_next = byte_count + 16'd1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      hex_high     <= 4'h0;
      byte_count   <= 16'h0000;
      gap_newlines <= 16'h0000;
    end else if (q_rd) begin
      mode         <= mode_next;
      hex_high     <= hex_high_next;
      byte_count   <= byte_count_next;
      gap_newlines <= gap_newlines_next;
    end
  end

  // Result storage is written at the tail.
  always_ff @(posedge clk) begin
    if (q_rd && out_wr) begin
      slots[wptr] <= out_data;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (q_rd && out_wr) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (out_rd) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if ((q_rd && out_wr) && !out_rd) begin
        count <= count + 1'b1;
      end else if (out_rd && !(q_rd && out_wr)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/string_literal_escape_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_decoder: decodes quoted string literals byte by byte
// Source bytes go in through a queue-like push/full port; decoded bytes,
// finish records and error records come out through an empty/pop port.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock cycle while full is low and
// returns at most one result item for each. A result shows on the output
// ports once its byte has passed through both queues: the front classifies
// the byte into a two-entry queue, and the back, whose mode register
// advances once per byte, writes the result into a two-entry output queue.
// The mode register of the back sets the rate; full rises only when the back
// has been held up by a stalled consumer long enough to fill both queues.
module string_literal_escape_decoder
  import sled_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        pop,
  output logic             empty,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [15:0]      length,
  output logic             empty_res,
  output logic [15:0]      newline_count
);

  logic q_wr;
  logic q_full;
  logic q_rd;
  logic q_valid;
  cls_t q_wdata;
  cls_t q_rdata;
  res_t res;

  // Front: accept and classify.
  sled_front u_front (
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .q_wr    (q_wr),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  // Queue between front and back.
  sled_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .valid   (q_valid)
  );

  // Back: literal state machine and result queue.
  sled_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  // Result fields.
  assign kind          = res.kind;
  assign data_byte     = res.data_byte;
  assign length        = res.length;
  assign empty_res     = res.empty_res;
  assign newline_count = res.newline_count;

endmodule
`default_nettype wire

// ===== hdl/sled_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_checker: port-level checks for the escape decoder
// Watches the result side of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module sled_checker
  import sled_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  data_byte,
  input wire logic [15:0] length,
  input wire logic        empty_res,
  input wire logic [15:0] newline_count
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // A waiting result that is not taken holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(data_byte)
                          && $stable(length) && $stable(newline_count)))
    else $error("waiting result changed or vanished");

  // A decoded byte carries no literal summary.
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_BYTE) |->
      (length == 16'h0000 && newline_count == 16'h0000 && !empty_res))
    else $error("decoded byte carries summary fields");

  // The empty flag of a finished literal agrees with its length.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_DONE) |-> (empty_res == (length == 16'h0000)))
    else $error("empty flag disagrees with length");

  // Error records carry only their kind.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_UNTERM || kind == KIND_BADESC)) |->
      (data_byte == 8'h00 && length == 16'h0000 && !empty_res
       && newline_count == 16'h0000))
    else $error("error record carries data");

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (.*);
`default_nettype wire
